>>> rtl/core/sld_pkg.sv
// shared constants, types and helpers for the sync and length packet deframer
package sld_pkg;

    localparam int HEADER_BYTES = 30;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 17;
    localparam int LEN_W  = 16;

    localparam logic [POS_W-1:0] LEN_HI_POS    = POS_W'(28);
    localparam logic [POS_W-1:0] LEN_LO_POS    = POS_W'(29);
    localparam logic [POS_W-1:0] SYNC_DONE_POS = POS_W'(4);
    localparam logic [POS_W-1:0] END_BASE      = POS_W'(HEADER_BYTES - 1);

    localparam logic [BYTE_W-1:0] SYNC_0 = 8'h30;
    localparam logic [BYTE_W-1:0] SYNC_1 = 8'h31;
    localparam logic [BYTE_W-1:0] SYNC_2 = 8'h63;
    localparam logic [BYTE_W-1:0] SYNC_3 = 8'h64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] sync_idx_t;

    localparam sync_idx_t SYNC_IDX_LAST = 2'd3;

    typedef struct packed {
        logic              burst;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_entry_t;

    typedef struct packed {
        logic          valid;
        result_entry_t entry;
    } result_push_t;

    function automatic logic [BYTE_W-1:0] sync_byte(input sync_idx_t idx);
        logic [BYTE_W-1:0] value;
        unique case (idx)
            2'd0: value = SYNC_0;
            2'd1: value = SYNC_1;
            2'd2: value = SYNC_2;
            2'd3: value = SYNC_3;
        endcase
        return value;
    endfunction

endpackage

>>> rtl/core/sld_parse.sv
// input register, sync hunt and length tracking for the deframer
module sld_parse (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sld_pkg::BYTE_W-1:0]       s_in_byte,
    output sld_pkg::result_push_t            push,
    input  logic                             push_ready
);

    logic                           in_valid_reg, in_valid_next;
    logic [sld_pkg::BYTE_W-1:0]     in_byte_reg, in_byte_next;
    sld_pkg::sync_idx_t             sync_matched_reg, sync_matched_next;
    logic                           in_packet_reg, in_packet_next;
    logic [sld_pkg::POS_W-1:0]      byte_pos_reg, byte_pos_next;
    logic [sld_pkg::LEN_W-1:0]      payload_len_reg, payload_len_next;

    logic                           advance;
    logic [sld_pkg::LEN_W-1:0]      len_upd;
    logic [sld_pkg::POS_W-1:0]      end_pos;
    logic                           pkt_last;

    assign s_ready = !in_valid_reg || push_ready;
    assign advance = in_valid_reg && push_ready;

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        in_byte_next  = (s_valid && s_ready) ? s_in_byte : in_byte_reg;
    end

    // length bytes are caught on the fly so the end compare sees them at once
    always_comb begin
        len_upd = payload_len_reg;
        if (byte_pos_reg == sld_pkg::LEN_HI_POS) begin
            len_upd = {in_byte_reg, payload_len_reg[7:0]};
        end else if (byte_pos_reg == sld_pkg::LEN_LO_POS) begin
            len_upd = {payload_len_reg[15:8], in_byte_reg};
        end
        end_pos  = sld_pkg::END_BASE + {1'b0, len_upd};
        pkt_last = (byte_pos_reg >= sld_pkg::LEN_LO_POS) && (byte_pos_reg >= end_pos);
    end

    always_comb begin
        sync_matched_next = sync_matched_reg;
        in_packet_next    = in_packet_reg;
        byte_pos_next     = byte_pos_reg;
        payload_len_next  = payload_len_reg;

        push.valid       = 1'b0;
        push.entry.burst = !in_packet_reg;
        push.entry.data  = in_byte_reg;
        push.entry.last  = in_packet_reg && pkt_last;

        if (advance) begin
            if (in_packet_reg) begin
                push.valid = 1'b1;
                if (pkt_last) begin
                    in_packet_next    = 1'b0;
                    byte_pos_next     = '0;
                    payload_len_next  = '0;
                    sync_matched_next = '0;
                end else begin
                    byte_pos_next    = byte_pos_reg + sld_pkg::POS_W'(1);
                    payload_len_next = len_upd;
                end
            end else if (in_byte_reg == sld_pkg::sync_byte(sync_matched_reg)) begin
                if (sync_matched_reg == sld_pkg::SYNC_IDX_LAST) begin
                    push.valid        = 1'b1;
                    sync_matched_next = '0;
                    in_packet_next    = 1'b1;
                    byte_pos_next     = sld_pkg::SYNC_DONE_POS;
                    payload_len_next  = '0;
                end else begin
                    sync_matched_next = sync_matched_reg + 2'd1;
                end
            end else begin
                // restart the match on this byte
                sync_matched_next = (in_byte_reg == sld_pkg::SYNC_0) ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            sync_matched_reg <= '0;
            in_packet_reg    <= 1'b0;
            byte_pos_reg     <= '0;
            payload_len_reg  <= '0;
        end else begin
            in_valid_reg     <= in_valid_next;
            sync_matched_reg <= sync_matched_next;
            in_packet_reg    <= in_packet_next;
            byte_pos_reg     <= byte_pos_next;
            payload_len_reg  <= payload_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_packet_reg |-> (sync_matched_reg == 2'd0))
        else $error("sync match count not cleared inside a packet");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_packet_reg |-> (byte_pos_reg >= sld_pkg::SYNC_DONE_POS))
        else $error("packet offset below the end of the sync word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> push_ready)
        else $error("result pushed into a full queue");

endmodule

>>> rtl/core/sld_out_queue.sv
// result queue that expands a sync entry into four output transactions
module sld_out_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sld_pkg::result_push_t            push,
    output logic                             push_ready,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sld_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                             m_first_byte,
    output logic                             m_last_byte
);

    sld_pkg::result_entry_t             storage_reg [sld_pkg::QUEUE_DEPTH];
    logic [sld_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [sld_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [sld_pkg::QCNT_W-1:0]         count_reg, count_next;
    sld_pkg::sync_idx_t                 sub_reg, sub_next;

    sld_pkg::result_entry_t             head;
    logic                               push_fire;
    logic                               out_fire;
    logic                               pop;

    assign push_ready = count_reg != sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH);
    assign push_fire  = push.valid && push_ready;

    assign head     = storage_reg[rd_ptr_reg];
    assign m_valid  = count_reg != '0;
    assign out_fire = m_valid && m_ready;
    assign pop      = out_fire && (!head.burst || sub_reg == sld_pkg::SYNC_IDX_LAST);

    assign m_out_byte   = head.burst ? sld_pkg::sync_byte(sub_reg) : head.data;
    assign m_first_byte = head.burst && (sub_reg == 2'd0);
    assign m_last_byte  = !head.burst && head.last;

    always_comb begin
        wr_ptr_next = push_fire ? wr_ptr_reg + sld_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + sld_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + sld_pkg::QCNT_W'(push_fire) - sld_pkg::QCNT_W'(pop);
        sub_next    = sub_reg;
        if (out_fire && head.burst) begin
            sub_next = sub_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            storage_reg[wr_ptr_reg] <= push.entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (sub_reg != 2'd0) |-> (m_valid && head.burst))
        else $error("sync expansion in progress without a sync entry at the head");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_first_byte) |-> (m_out_byte == sld_pkg::SYNC_0))
        else $error("first byte of a packet is not the first sync byte");

endmodule

>>> rtl/core/sync_length_packet_deframer.sv
// Sync word and length packet deframer: takes one stream byte per cycle and
// forwards framed packets. The s_ channel accepts a byte in every cycle as long
// as the four-entry output queue has room; accepted bytes pass through the input
// register and the output queue before they reach the m_ channel. While hunting,
// bytes are dropped; the byte that completes the sync word 30 31 63 64 yields
// four output transactions (first_byte on the 0x30), and every later packet
// byte yields one, up to the end set by the big-endian length in header bytes
// 28 and 29. The m_ port, one transaction per cycle while m_ready is high, sets
// the sustained rate: each packet yields as many output transactions as it has
// input bytes.
module sync_length_packet_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sld_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sld_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                         m_first_byte,
    output logic                         m_last_byte
);

    sld_pkg::result_push_t push;
    logic                  push_ready;

    sld_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .push       (push),
        .push_ready (push_ready)
    );

    sld_out_queue u_out_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .push_ready   (push_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_first_byte (m_first_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule
